>>> hw/rtl/free_fall_detector_macros.svh
// ---------------------------------------------------------------------------
// Free-fall detector assertion macros
// Shared concurrent assertion forms, clocked on clk_i, reset on rst_ni.
// ---------------------------------------------------------------------------
`ifndef FREE_FALL_DETECTOR_MACROS_SVH
`define FREE_FALL_DETECTOR_MACROS_SVH

// same-cycle implication
`define FFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ffd_pkg.sv
// ---------------------------------------------------------------------------
// ffd_pkg
// Constants shared by the free-fall detector and its checker.
// ---------------------------------------------------------------------------
package ffd_pkg;

  // phase codes
  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_WAIT  = 2'd1;
  localparam logic [1:0] PH_FALL  = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  // tick mark codes
  localparam logic [1:0] TICK_NONE = 2'd0;
  localparam logic [1:0] TICK_WAIT = 2'd1;
  localparam logic [1:0] TICK_FALL = 2'd2;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_FALL_LEVEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMPACT_LEVEL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_WINDOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_REARM      = 3'd4;

  localparam logic [31:0] RST_FREE_FALL_LEVEL = 32'd167772;
  localparam logic [31:0] RST_IMPACT_LEVEL    = 32'd150994944;
  localparam logic [15:0] RST_TICK_PERIOD     = 16'd700;
  localparam logic [15:0] RST_TICK_WINDOW     = 16'd30;
  localparam logic [15:0] RST_TICK_REARM      = 16'd50;

  // distance = (d*d*DIST_SCALE) >> DIST_SHIFT mm
  localparam logic [12:0] DIST_SCALE = 13'd5143;
  localparam int unsigned DIST_SHIFT = 20;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned DUR_W  = 16;
  localparam int unsigned DIST_W = 25;

  // result tdata layout
  localparam int unsigned OUT_MARK_LSB  = 0;
  localparam int unsigned OUT_START_BIT = 2;
  localparam int unsigned OUT_END_BIT   = 3;
  localparam int unsigned OUT_DUR_LSB   = 4;
  localparam int unsigned OUT_DIST_LSB  = OUT_DUR_LSB + DUR_W;
  localparam int unsigned OUT_PHASE_LSB = OUT_DIST_LSB + DIST_W;
  localparam int unsigned OUT_USED_W    = OUT_PHASE_LSB + 2;
  localparam int unsigned OUT_W         = ((OUT_USED_W + 7) / 8) * 8;

endpackage

>>> hw/rtl/free_fall_detector.sv
// ---------------------------------------------------------------------------
// free_fall_detector
// Free-fall detection on timestamped three-axis samples, one shared
// multiplier and a bit-serial modulo unit under a small sequencer.
// ---------------------------------------------------------------------------
// channel   dir  handshake               payload
// s_axis    in   tvalid/tready           time_ms, accel_x, accel_y, accel_z
// m_axis    out  tvalid/tready           tick_mark .. phase_now
// cfg       in   cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//
// Per transaction: accept, the squares on the shared multiplier, the modulo
// (one quotient bit a cycle; skipped when the period register is zero),
// evaluate, the distance products when the fall ends, then load the
// output.
// Output register frees the core once loaded; a stalled result holds the
// core only at its final cycle. Reset is asynchronous and restores defaults.
// ---------------------------------------------------------------------------
module free_fall_detector #(
  parameter int unsigned ACCEL_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // time_ms, accel_x, accel_y, accel_z, zero fill
  input  logic [((32+3*ACCEL_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tick_mark, fall_started, fall_ended, fall_duration, fall_distance,
  // phase_now, zero fill
  output logic [ffd_pkg::OUT_W-1:0]         m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [ffd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ffd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import ffd_pkg::*;

  localparam int unsigned AW   = ACCEL_WIDTH;
  localparam int unsigned MW   = (AW > 32) ? AW : 32;
  localparam int unsigned SQW  = 2 * AW;
  localparam int unsigned MAGW = SQW + 2;
  localparam int unsigned CMPW = (MAGW > 32) ? MAGW : 32;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQR  = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_MUL1 = 3'd4;
  localparam logic [2:0] S_MUL2 = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [4:0]           cnt_q, cnt_d;
  logic [31:0]          ffl_q, imp_q;
  logic [15:0]          per_q, win_q, rearm_q;
  logic [1:0]           phase_q, phase_d;
  logic                 td_q, td_d;
  logic [TIME_W-1:0]    start_q, start_d;
  logic [TIME_W-1:0]    t_q;
  logic [AW-1:0]        ax_q, ay_q, az_q;
  logic [MAGW-1:0]      acc_q, acc_d;
  logic [2*MW-1:0]      prod_q, prod_d;
  logic [15:0]          rem_q, rem_d;
  logic [1:0]           mark_q, mark_d, now_q, now_d;
  logic                 started_q, started_d, ended_q, ended_d;
  logic [DUR_W-1:0]     dur_q, dur_d;
  logic                 m_valid_q;
  logic [OUT_W-1:0]     m_data_q;

  logic [AW-1:0]        sel_axis, abs_axis;
  logic [MW-1:0]        mul_a, mul_b;
  logic [2*MW-1:0]      mul_p;
  logic [16:0]          rem_sh;
  logic                 in_acc, fin_go;

  logic                 fire_w, fire_f, td_w, td_in, td_f, fall_now;
  logic                 below, above;
  logic [TIME_W-1:0]    elapsed;
  logic [DIST_W-1:0]    dist_mm;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign fin_go        = (state_q == S_FIN) && (!m_valid_q || m_axis_tready);

  // shared multiplier operand select
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    sel_axis = ax_q;
      2'd1:    sel_axis = ay_q;
      default: sel_axis = az_q;
    endcase
    abs_axis = sel_axis[AW-1] ? (~sel_axis + 1'b1) : sel_axis;
    case (state_q)
      S_MUL1: begin
        mul_a = MW'(dur_q);
        mul_b = MW'(dur_q);
      end
      S_MUL2: begin
        mul_a = prod_q[MW-1:0];
        mul_b = MW'(DIST_SCALE);
      end
      default: begin
        mul_a = MW'(abs_axis);
        mul_b = MW'(abs_axis);
      end
    endcase
  end
  assign mul_p  = mul_a * mul_b;
  assign rem_sh = {rem_q, t_q[cnt_q]};

  // level compares and tick rule
  always_comb begin
    below    = CMPW'(acc_q) < CMPW'(ffl_q);
    above    = CMPW'(acc_q) > CMPW'(imp_q);
    fire_w   = (rem_q < win_q) && !td_q;
    td_w     = (td_q || fire_w) && !(rem_q > rearm_q);
    fall_now = (phase_q == PH_FALL) || ((phase_q == PH_WAIT) && below);
    td_in    = (phase_q == PH_WAIT) ? 1'b0 : td_q;
    fire_f   = (rem_q < win_q) && !td_in;
    td_f     = (td_in || fire_f) && !(rem_q > rearm_q);
    elapsed  = t_q - ((phase_q == PH_WAIT) ? t_q : start_q);
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    prod_d    = prod_q;
    rem_d     = rem_q;
    phase_d   = phase_q;
    td_d      = td_q;
    start_d   = start_q;
    mark_d    = mark_q;
    now_d     = now_q;
    started_d = started_q;
    ended_d   = ended_q;
    dur_d     = dur_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_SQR;
          cnt_d   = '0;
          acc_d   = '0;
        end
      end
      S_SQR: begin
        if (cnt_q[1:0] != 2'd3) prod_d = mul_p;
        if (cnt_q[1:0] != 2'd0) acc_d = acc_q + MAGW'(prod_q[SQW-1:0]);
        if (cnt_q[1:0] == 2'd3) begin
          state_d = S_MOD;
          cnt_d   = 5'd31;
          rem_d   = '0;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_MOD: begin
        if (per_q == '0) begin
          rem_d   = t_q[15:0];
          state_d = S_EVAL;
        end else begin
          rem_d = (rem_sh >= {1'b0, per_q}) ? 16'(rem_sh - {1'b0, per_q}) : rem_sh[15:0];
          if (cnt_q == '0) state_d = S_EVAL;
          else             cnt_d = cnt_q - 5'd1;
        end
      end
      S_EVAL: begin
        now_d     = phase_q;
        mark_d    = TICK_NONE;
        started_d = 1'b0;
        ended_d   = 1'b0;
        dur_d     = '0;
        case (phase_q)
          PH_FIRST: phase_d = PH_WAIT;
          PH_WAIT: begin
            if (fire_w) mark_d = TICK_WAIT;
            td_d = td_w;
            if (below) begin
              started_d = 1'b1;
              start_d   = t_q;
              phase_d   = PH_FALL;
            end
          end
          default: ;
        endcase
        if (fall_now) begin
          if (fire_f) mark_d = TICK_FALL;
          td_d = td_f;
          if (above) begin
            ended_d = 1'b1;
            dur_d   = (elapsed > TIME_W'({DUR_W{1'b1}})) ? {DUR_W{1'b1}}
                                                         : elapsed[DUR_W-1:0];
            phase_d = PH_DONE;
          end
        end
        state_d = (fall_now && above) ? S_MUL1 : S_FIN;
      end
      S_MUL1: begin
        prod_d  = mul_p;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        prod_d  = mul_p;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (fin_go) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign dist_mm = ended_q ? prod_q[DIST_SHIFT +: DIST_W] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      phase_q   <= PH_FIRST;
      td_q      <= 1'b0;
      start_q   <= '0;
      ffl_q     <= RST_FREE_FALL_LEVEL;
      imp_q     <= RST_IMPACT_LEVEL;
      per_q     <= RST_TICK_PERIOD;
      win_q     <= RST_TICK_WINDOW;
      rearm_q   <= RST_TICK_REARM;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      td_q    <= td_d;
      start_q <= start_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FREE_FALL_LEVEL: ffl_q   <= cfg_data_i[31:0];
          CFG_IMPACT_LEVEL:    imp_q   <= cfg_data_i[31:0];
          CFG_TICK_PERIOD:     per_q   <= cfg_data_i[15:0];
          CFG_TICK_WINDOW:     win_q   <= cfg_data_i[15:0];
          CFG_TICK_REARM:      rearm_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (fin_go)             m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      t_q  <= s_axis_tdata[TIME_W-1:0];
      ax_q <= s_axis_tdata[TIME_W +: AW];
      ay_q <= s_axis_tdata[TIME_W+AW +: AW];
      az_q <= s_axis_tdata[TIME_W+2*AW +: AW];
    end
    acc_q     <= acc_d;
    prod_q    <= prod_d;
    rem_q     <= rem_d;
    mark_q    <= mark_d;
    now_q     <= now_d;
    started_q <= started_d;
    ended_q   <= ended_d;
    dur_q     <= dur_d;
    if (fin_go) begin
      m_data_q <= {{(OUT_W-OUT_USED_W){1'b0}}, now_q, dist_mm, dur_q, ended_q, started_q,
                   mark_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

>>> hw/rtl/ffd_checker.sv
// ---------------------------------------------------------------------------
// ffd_checker
// Port-level checks on the free-fall detector result stream.
// ---------------------------------------------------------------------------
`include "free_fall_detector_macros.svh"

module ffd_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [ffd_pkg::OUT_W-1:0] m_axis_tdata
);
  import ffd_pkg::*;

  logic [1:0] mark, ph;
  logic       started, ended;
  logic [DUR_W-1:0]  dur;
  logic [DIST_W-1:0] fall_dist;
  logic       len_zero, active_ph, quiet_ph, quiet_out, stall;

  assign mark      = m_axis_tdata[OUT_MARK_LSB +: 2];
  assign started   = m_axis_tdata[OUT_START_BIT];
  assign ended     = m_axis_tdata[OUT_END_BIT];
  assign dur       = m_axis_tdata[OUT_DUR_LSB +: DUR_W];
  assign fall_dist = m_axis_tdata[OUT_DIST_LSB +: DIST_W];
  assign ph        = m_axis_tdata[OUT_PHASE_LSB +: 2];

  assign len_zero  = (dur == '0) && (fall_dist == '0);
  assign active_ph = (ph == PH_WAIT) || (ph == PH_FALL);
  assign quiet_ph  = (ph == PH_FIRST) || (ph == PH_DONE);
  assign quiet_out = (mark == TICK_NONE) && !started && !ended;
  assign stall     = m_axis_tvalid && !m_axis_tready;

  `FFD_ASSERT_IMP(a_no_len_without_end, m_axis_tvalid && !ended, len_zero, "length without end")
  `FFD_ASSERT_IMP(a_start_only_waiting, m_axis_tvalid && started, ph == PH_WAIT, "start not waiting")
  `FFD_ASSERT_IMP(a_end_phase, m_axis_tvalid && ended, active_ph, "fall end outside fall")
  `FFD_ASSERT_IMP(a_quiet_phases, m_axis_tvalid && quiet_ph, quiet_out, "activity first or done")
  `FFD_ASSERT_NXT(a_hold_stalled, stall, m_axis_tvalid && $stable(m_axis_tdata), "stall changed")

endmodule

bind free_fall_detector ffd_checker u_ffd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

>>> sim/free_fall_detector_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// free_fall_detector_tb
// Streams timestamped accelerometer samples into the detector and checks
// every result against an in-bench model of the phase sequencer, the tick
// mark rule and the duration/distance math. Runs the block through the
// waiting phase, a long fall, the impact and the done phase, with register
// writes between phases, random sender gaps, receiver stalls and a long
// receiver hold-off.
// ---------------------------------------------------------------------------
module free_fall_detector_tb;
  import ffd_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam logic [31:0] LEVEL_MAX    = 32'hC000_0000;

  typedef struct packed {
    logic [1:0]        phase_now;
    logic [DIST_W-1:0] fall_distance;
    logic [DUR_W-1:0]  fall_duration;
    logic              fall_ended;
    logic              fall_started;
    logic [1:0]        tick_mark;
  } fall_result_t;

  class free_fall_scoreboard;
    logic [31:0] free_fall_level;
    logic [31:0] impact_level;
    logic [15:0] tick_period;
    logic [15:0] tick_window;
    logic [15:0] tick_rearm;
    logic [1:0]  phase;
    bit          tick_done;
    logic [31:0] fall_start;
    fall_result_t expected_q[$];
    int unsigned errors;
    int unsigned n_samples;
    int unsigned n_ticks;
    int unsigned n_starts;
    int unsigned n_ends;
    int unsigned n_done;

    function new();
      free_fall_level = RST_FREE_FALL_LEVEL;
      impact_level    = RST_IMPACT_LEVEL;
      tick_period     = RST_TICK_PERIOD;
      tick_window     = RST_TICK_WINDOW;
      tick_rearm      = RST_TICK_REARM;
      phase           = PH_FIRST;
      tick_done       = 1'b0;
      fall_start      = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        CFG_FREE_FALL_LEVEL: free_fall_level = val;
        CFG_IMPACT_LEVEL:    impact_level = val;
        CFG_TICK_PERIOD:     tick_period = val[15:0];
        CFG_TICK_WINDOW:     tick_window = val[15:0];
        CFG_TICK_REARM:      tick_rearm = val[15:0];
        default: ;
      endcase
    endfunction

    function bit tick_fires(logic [31:0] t);
      logic [31:0] r;
      bit fired;
      r = (tick_period == 16'd0) ? {16'd0, t[15:0]} : t % {16'd0, tick_period};
      fired = 1'b0;
      if (r < {16'd0, tick_window} && !tick_done) begin
        tick_done = 1'b1;
        fired = 1'b1;
      end
      if (r > {16'd0, tick_rearm} && tick_done)
        tick_done = 1'b0;
      return fired;
    endfunction

    function void note_sample(logic [31:0] t, logic signed [15:0] ax,
                              logic signed [15:0] ay, logic signed [15:0] az);
      fall_result_t r;
      longint mag;
      logic [31:0] span;
      logic [15:0] dur;
      longint unsigned dist_mm;
      bit falling;
      r = '0;
      r.phase_now = phase;
      falling = 1'b0;
      mag = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
      case (phase)
        PH_FIRST: phase = PH_WAIT;
        PH_WAIT: begin
          if (tick_fires(t))
            r.tick_mark = TICK_WAIT;
          if (mag < longint'({32'd0, free_fall_level})) begin
            r.fall_started = 1'b1;
            fall_start = t;
            tick_done = 1'b0;
            phase = PH_FALL;
            falling = 1'b1;
          end
        end
        PH_FALL: falling = 1'b1;
        default: ;
      endcase
      if (falling) begin
        if (tick_fires(t))
          r.tick_mark = TICK_FALL;
        if (mag > longint'({32'd0, impact_level})) begin
          span = t - fall_start;
          dur = (span > 32'd65535) ? 16'hFFFF : span[15:0];
          dist_mm = (longint'(dur) * dur * DIST_SCALE) >> DIST_SHIFT;
          r.fall_ended = 1'b1;
          r.fall_duration = dur;
          r.fall_distance = dist_mm[DIST_W-1:0];
          phase = PH_DONE;
        end
      end
      n_samples++;
      if (r.tick_mark != TICK_NONE) n_ticks++;
      if (r.fall_started) n_starts++;
      if (r.fall_ended) n_ends++;
      if (r.phase_now == PH_DONE) n_done++;
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_field(string name, longint unsigned got, longint unsigned want);
      if (got != want)
        report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(fall_result_t got);
      fall_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing outstanding", got));
        return;
      end
      want = expected_q.pop_front();
      check_field("tick_mark", got.tick_mark, want.tick_mark);
      check_field("fall_started", got.fall_started, want.fall_started);
      check_field("fall_ended", got.fall_ended, want.fall_ended);
      check_field("fall_duration", got.fall_duration, want.fall_duration);
      check_field("fall_distance", got.fall_distance, want.fall_distance);
      check_field("phase_now", got.phase_now, want.phase_now);
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [79:0]           s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  free_fall_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        rx_hold = 1'b0;
  logic [31:0] t_now = '0;

  free_fall_detector #(.ACCEL_WIDTH(16)) u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("TB_ERROR");
    $finish;
  end

  // receiver: random stalls plus a counted hold-off on request
  always @(posedge clk_i) begin
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_sample(s_axis_tdata[31:0], s_axis_tdata[47:32], s_axis_tdata[63:48],
                     s_axis_tdata[79:64]);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[OUT_USED_W-1:0]);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_ticks(logic [15:0] period, logic [15:0] window, logic [15:0] rearm);
    write_reg(CFG_TICK_PERIOD, {16'd0, period});
    write_reg(CFG_TICK_WINDOW, {16'd0, window});
    write_reg(CFG_TICK_REARM, {16'd0, rearm});
  endtask

  task automatic send_sample(logic [31:0] t, logic [15:0] ax, logic [15:0] ay,
                             logic [15:0] az);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (send_idle_pct != 0 && $urandom_range(9) == 0)
      gap += $urandom_range(1, 80);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {az, ay, ax, t};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // mostly a running millisecond counter, sometimes a jump anywhere
  task automatic run_random(int unsigned n, int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n) begin
      if ($urandom_range(9) < 7)
        t_now += $urandom_range(0, 80);
      else
        t_now = $urandom();
      send_sample(t_now, 16'($urandom()), 16'($urandom()), 16'($urandom()));
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] per;
    logic [15:0] win;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // first sample is dropped, then waiting with defaults
    send_sample(32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_sample(32'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(32'd29, 16'h8000, 16'h8000, 16'h8000);
    send_sample(32'd30, 16'd4096, 16'd0, 16'd0);
    send_sample(32'd50, 16'd0, 16'd4096, 16'd0);
    send_sample(32'd51, 16'd0, 16'd0, -16'sd4096);
    send_sample(32'd700, 16'd410, 16'd0, 16'd0);
    send_sample(32'd729, 16'd0, -16'sd410, 16'd0);
    send_sample(32'd751, 16'd1, 16'd2, -16'sd4096);
    send_sample(32'd1429, 16'd4096, 16'd4096, 16'd4096);
    send_sample(32'h8000_0000, 16'h7FFF, 16'h8000, 16'h0001);
    send_sample(32'hFFFF_FFFF, 16'h5555, 16'hAAAA, 16'h0F0F);
    send_sample(32'h0000_0001, 16'hF0F0, 16'h3333, 16'hCCCC);
    drain();

    // waiting: a zero start level keeps the block from falling
    write_reg(CFG_FREE_FALL_LEVEL, 32'd0);
    write_reg(CFG_IMPACT_LEVEL, $urandom_range(0, LEVEL_MAX));
    set_ticks(16'd1, 16'd1, 16'd0);
    run_random(180, 0, 0);
    drain();
    set_ticks(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(180, 63, 0);
    drain();
    set_ticks(16'd0, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    run_random(200, 0, 63);
    drain();
    per = 16'($urandom_range(50, 2000));
    win = 16'($urandom_range(0, per));
    set_ticks(per, win, 16'($urandom_range(win, per)));
    run_random(220, 32, 32);
    drain();

    // fall start: full-scale magnitude sits on the level, zero drops below it
    write_reg(CFG_FREE_FALL_LEVEL, LEVEL_MAX);
    write_reg(CFG_IMPACT_LEVEL, LEVEL_MAX);
    set_ticks(16'd100, 16'd20, 16'd40);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    t_now = 32'd5110;
    send_sample(32'd5060, 16'h8000, 16'h8000, 16'h8000);
    send_sample(32'd5105, 16'd0, 16'd0, 16'd0);
    send_sample(t_now, 16'd12, -16'sd7, 16'd3);
    drain();

    // falling, impact level at full scale so the fall keeps going
    hold_go = 1'b1;
    run_random(120, 0, 0);
    drain();
    write_reg(CFG_FREE_FALL_LEVEL, 32'd0);
    set_ticks(16'd0, 16'd0, 16'hFFFF);
    run_random(160, 63, 0);
    drain();
    per = 16'($urandom_range(20, 3000));
    win = 16'($urandom_range(0, per));
    set_ticks(per, win, 16'($urandom_range(win, per)));
    run_random(220, 0, 63);
    drain();
    set_ticks(16'd1000, 16'd1000, 16'd0);
    run_random(160, 32, 32);
    drain();

    // impact: equal to the level does not end it, one step above does
    write_reg(CFG_IMPACT_LEVEL, 32'h0100_0000);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_sample(sb.fall_start + 32'd1000, 16'd4096, 16'd0, 16'd0);
    send_sample(sb.fall_start + 32'd70000, -16'sd4097, 16'd0, 16'd0);
    drain();

    // done phase ignores everything
    write_reg(CFG_IMPACT_LEVEL, 32'd0);
    write_reg(CFG_FREE_FALL_LEVEL, LEVEL_MAX);
    set_ticks(16'($urandom_range(1, 65535)), 16'hFFFF, 16'd0);
    run_random(40, 32, 32);
    drain();

    $display("%0d samples: %0d tick marks, %0d fall starts, %0d impacts, %0d after impact",
             sb.n_samples, sb.n_ticks, sb.n_starts, sb.n_ends, sb.n_done);
    $display("tick periods from zero to full scale, levels at both extremes, %0d mismatches",
             sb.errors);
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
